FILE: sv/bgc_pkg.sv
// Package for the Big5 / GB2312 code converter.
// Holds the beat types, the code range limits and the replacement codes.
// No dependencies.
package bgc_pkg;

   // One output beat: a byte and its end-of-string flag.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } bgc_beat_type;

   // Push request from the lookup stage into the output queue.
   typedef struct packed {
      logic         valid;
      logic         two;
      bgc_beat_type first;
      bgc_beat_type second;
   } bgc_push_type;

   // Output queue geometry.
   localparam int unsigned OQ_DEPTH = 4;
   localparam int unsigned OQ_AW    = 2;
   localparam int unsigned OQ_CW    = 3;

   // Big5 ranges.
   localparam logic [7:0] B5_LEAD_LO    = 8'ha1;
   localparam logic [7:0] B5_LEAD_HI    = 8'hf9;
   localparam logic [7:0] B5_TRAIL1_LO  = 8'h40;
   localparam logic [7:0] B5_TRAIL1_HI  = 8'h7e;
   localparam logic [7:0] B5_TRAIL2_LO  = 8'ha1;
   localparam logic [7:0] B5_TRAIL2_HI  = 8'hfe;
   localparam logic [7:0] B5_TRAIL2_OFS = 8'd63;
   localparam logic [7:0] B5_ROW_LEN    = 8'd157;

   // GB2312 ranges.
   localparam logic [7:0] GB_TRAIL_LO   = 8'ha1;
   localparam logic [7:0] GB_TRAIL_HI   = 8'hfe;
   localparam logic [7:0] GB_LEAD1_LO   = 8'ha1;
   localparam logic [7:0] GB_LEAD1_HI   = 8'ha9;
   localparam logic [7:0] GB_LEAD2_LO   = 8'hb0;
   localparam logic [7:0] GB_LEAD2_HI   = 8'hf7;
   localparam logic [7:0] GB_LEAD2_ROW  = 8'd9;
   localparam logic [7:0] GB_ROW_LEN    = 8'd94;

   // Replacement pairs for each direction.
   localparam logic [15:0] B5_TO_GB_REPL = 16'ha1f5;
   localparam logic [15:0] GB_TO_B5_REPL = 16'ha1bc;

   // Direction register codes.
   localparam logic DIR_BIG5_TO_GB = 1'b0;
   localparam logic DIR_GB_TO_BIG5 = 1'b1;

   // Input item kinds.
   localparam logic MODE_CONVERT = 1'b0;
   localparam logic MODE_LOAD    = 1'b1;

   // Table selector codes of a load beat.
   localparam logic TABLE_BIG5_TO_GB = 1'b0;
   localparam logic TABLE_GB_TO_BIG5 = 1'b1;

endpackage

FILE: sv/bgc_table_ram.sv
// Single-port synchronous table memory with a registered read.
// Used for both code tables of the converter. No package dependencies.
module bgc_table_ram #(
   parameter int unsigned DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [15:0]              wdata,
   output logic [15:0]              rdata
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rdata_ff;

   // A write or a read each enabled cycle; read data holds otherwise.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/bgc_out_queue.sv
// Output queue of the converter: takes one or two beats a cycle, sends one while rsp_tready is high.
// Depends on bgc_pkg for the beat and push types.
module bgc_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  bgc_pkg::bgc_push_type push,
   output logic                  room,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output bgc_pkg::bgc_beat_type head
);
   import bgc_pkg::*;

   bgc_beat_type       mem [OQ_DEPTH];
   logic [OQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OQ_CW-1:0]   count_ff, count_in;
   logic [OQ_CW-1:0]   push_n;
   logic               pop;

   // Room for a full pair, judged on the registered count alone.
   assign room       = (count_ff <= OQ_CW'(OQ_DEPTH - 2));
   assign rsp_tvalid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];
   assign pop        = rsp_tvalid && rsp_tready;

   // Pointer and count updates.
   always_comb begin
      push_n    = push.valid ? (push.two ? OQ_CW'(2) : OQ_CW'(1)) : '0;
      wr_ptr_in = wr_ptr_ff + OQ_AW'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + OQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + push_n - (pop ? OQ_CW'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Beat storage; the second beat of a pair goes one place further on.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.first;
         if (push.two) begin
            mem[wr_ptr_ff + OQ_AW'(1)] <= push.second;
         end
      end
   end

endmodule

FILE: sv/big5_gb_code_converter_core.sv
// Top level of the Big5 / GB2312 code converter: lead byte tracking, index
// calculation, table lookup stage. Depends on bgc_pkg, bgc_table_ram, bgc_out_queue.
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_tvalid/req_tready req_tdata, req_tlast, req_tuser
//  rsp      out        rsp_tvalid/rsp_tready rsp_tdata, rsp_tlast
//  csr      in         csr_valid/csr_ready   csr_data (direction)
//
// One input beat is taken per cycle while req_tready is high. A converted pair
// is read from its table into the lookup stage, then pushed into the queue.
// The table memories have one port each, so a load and a lookup share it.
// Synchronous reset clears the held lead byte, the direction and the queue;
// the tables are not cleared and must be loaded before use.
// The input stalls only when the lookup stage holds a result and the output
// queue lacks room for a pair.
module big5_gb_code_converter_core #(
   parameter int unsigned BIG5_TABLE_DEPTH = 16384,
   parameter int unsigned GB_TABLE_DEPTH   = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // data_byte[7:0], table_index[21:8], table_word[37:22]
   input  logic        req_tlast,  // last_byte
   input  logic [1:0]  req_tuser,  // mode[0], table_select[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte[7:0]
   output logic        rsp_tlast,  // out_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data    // direction
);
   import bgc_pkg::*;

   localparam int unsigned B5_AW    = $clog2(BIG5_TABLE_DEPTH);
   localparam int unsigned GB_AW    = $clog2(GB_TABLE_DEPTH);
   localparam logic [14:0] B5_LIMIT = 15'(BIG5_TABLE_DEPTH);
   localparam logic [13:0] GB_LIMIT = 14'(GB_TABLE_DEPTH);

   // Input fields.
   logic        mode;
   logic        tsel;
   logic [7:0]  data_byte;
   logic [13:0] table_index;
   logic [15:0] table_word;
   logic        req_acc;

   // Lead byte state and direction register.
   logic        pending_ff, pending_in;
   logic [7:0]  lead_ff, lead_in;
   logic        dir_ff, dir_in;

   // Pair formation and index calculation.
   logic [7:0]  lead;
   logic [7:0]  trail;
   logic        pair_last;
   logic        is_pair;
   logic        is_single;
   logic        b5_lead_ok, b5_t1, b5_t2, b5_ok;
   logic [6:0]  b5_row;
   logic [7:0]  b5_col;
   logic [13:0] b5_idx;
   logic        gb_trail_ok, gb_l1, gb_l2, gb_ok;
   logic [6:0]  gb_row;
   logic [12:0] gb_idx;
   logic        pair_ok;
   logic        load_b5_ok, load_gb_ok;

   // Memory ports.
   logic             b5_en, gb_en;
   logic [B5_AW-1:0] b5_addr;
   logic [GB_AW-1:0] gb_addr;
   logic [15:0]      b5_rdata, gb_rdata;

   // Lookup stage.
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_pair_ff;
   logic        s1_repl_ff;
   logic        s1_dir_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic [15:0] code;
   logic        room;

   bgc_push_type push;
   bgc_beat_type head;

   assign mode        = req_tuser[0];
   assign tsel        = req_tuser[1];
   assign data_byte   = req_tdata[7:0];
   assign table_index = req_tdata[21:8];
   assign table_word  = req_tdata[37:22];

   assign req_tready = !s1_valid_ff || room;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Classify the beat and pick the lead and trail of a pair.
   always_comb begin
      is_pair   = (mode == MODE_CONVERT) && (pending_ff || (data_byte[7] && req_tlast));
      is_single = (mode == MODE_CONVERT) && !pending_ff && !data_byte[7];
      lead      = pending_ff ? lead_ff : data_byte;
      trail     = pending_ff ? data_byte : 8'h00;
      pair_last = pending_ff ? req_tlast : 1'b1;
   end

   // Big5 index: row of 157 codes, two trail ranges.
   always_comb begin
      b5_lead_ok = (lead >= B5_LEAD_LO) && (lead <= B5_LEAD_HI);
      b5_t1      = (trail >= B5_TRAIL1_LO) && (trail <= B5_TRAIL1_HI);
      b5_t2      = (trail >= B5_TRAIL2_LO) && (trail <= B5_TRAIL2_HI);
      b5_row     = 7'(lead - B5_LEAD_LO);
      b5_col     = b5_t1 ? 8'(trail - B5_TRAIL1_LO)
                         : 8'(trail - B5_TRAIL2_LO + B5_TRAIL2_OFS);
      b5_idx     = 14'(b5_row) * 14'(B5_ROW_LEN) + 14'(b5_col);
      b5_ok      = b5_lead_ok && (b5_t1 || b5_t2) && ({1'b0, b5_idx} < B5_LIMIT);
   end

   // GB2312 index: row of 94 codes, two lead blocks.
   always_comb begin
      gb_trail_ok = (trail >= GB_TRAIL_LO) && (trail <= GB_TRAIL_HI);
      gb_l1       = (lead >= GB_LEAD1_LO) && (lead <= GB_LEAD1_HI);
      gb_l2       = (lead >= GB_LEAD2_LO) && (lead <= GB_LEAD2_HI);
      gb_row      = gb_l1 ? 7'(lead - GB_LEAD1_LO)
                          : 7'(lead - GB_LEAD2_LO + GB_LEAD2_ROW);
      gb_idx      = 13'(gb_row) * 13'(GB_ROW_LEN) + 13'(trail - GB_TRAIL_LO);
      gb_ok       = gb_trail_ok && (gb_l1 || gb_l2) && ({1'b0, gb_idx} < GB_LIMIT);
   end

   assign pair_ok    = (dir_ff == DIR_GB_TO_BIG5) ? gb_ok : b5_ok;
   assign load_b5_ok = ({1'b0, table_index} < B5_LIMIT);
   assign load_gb_ok = (table_index < GB_LIMIT);

   // Memory port control: a load writes, a valid pair reads the active table.
   always_comb begin
      b5_en = req_acc &&
              (((mode == MODE_LOAD) && (tsel == TABLE_BIG5_TO_GB) && load_b5_ok) ||
               (is_pair && (dir_ff == DIR_BIG5_TO_GB) && b5_ok));
      gb_en = req_acc &&
              (((mode == MODE_LOAD) && (tsel == TABLE_GB_TO_BIG5) && load_gb_ok) ||
               (is_pair && (dir_ff == DIR_GB_TO_BIG5) && gb_ok));
      b5_addr = (mode == MODE_LOAD) ? table_index[B5_AW-1:0] : b5_idx[B5_AW-1:0];
      gb_addr = (mode == MODE_LOAD) ? table_index[GB_AW-1:0] : gb_idx[GB_AW-1:0];
   end

   bgc_table_ram #(.DEPTH(BIG5_TABLE_DEPTH)) u_b5_table (
      .clock (clock),
      .en    (b5_en),
      .we    (mode),
      .addr  (b5_addr),
      .wdata (table_word),
      .rdata (b5_rdata)
   );

   bgc_table_ram #(.DEPTH(GB_TABLE_DEPTH)) u_gb_table (
      .clock (clock),
      .en    (gb_en),
      .we    (mode),
      .addr  (gb_addr),
      .wdata (table_word),
      .rdata (gb_rdata)
   );

   // Next values of the lead byte state and the direction register.
   always_comb begin
      pending_in = pending_ff;
      lead_in    = lead_ff;
      if (req_acc && (mode == MODE_CONVERT)) begin
         pending_in = !pending_ff && data_byte[7] && !req_tlast;
         if (!pending_ff && data_byte[7] && !req_tlast) begin
            lead_in = data_byte;
         end
      end
      dir_in = (csr_valid && csr_ready) ? csr_data : dir_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         lead_ff    <= 8'h00;
         dir_ff     <= DIR_BIG5_TO_GB;
      end else begin
         pending_ff <= pending_in;
         lead_ff    <= lead_in;
         dir_ff     <= dir_in;
      end
   end

   // Lookup stage: holds its beat until the queue has room.
   assign s1_valid_in = req_tready ? (req_acc && (is_pair || is_single)) : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pair_ff <= is_pair;
         s1_repl_ff <= !pair_ok;
         s1_dir_ff  <= dir_ff;
         s1_byte_ff <= data_byte;
         s1_last_ff <= is_pair ? pair_last : req_tlast;
      end
   end

   // Choose the table word or the replacement pair of the direction taken.
   always_comb begin
      if (s1_repl_ff) begin
         code = (s1_dir_ff == DIR_GB_TO_BIG5) ? GB_TO_B5_REPL : B5_TO_GB_REPL;
      end else begin
         code = (s1_dir_ff == DIR_GB_TO_BIG5) ? gb_rdata : b5_rdata;
      end
   end

   // Beats into the queue: the high byte first for a pair.
   always_comb begin
      push.valid       = s1_valid_ff && room;
      push.two         = s1_pair_ff;
      push.first.data  = s1_pair_ff ? code[15:8] : s1_byte_ff;
      push.first.last  = s1_pair_ff ? 1'b0 : s1_last_ff;
      push.second.data = code[7:0];
      push.second.last = s1_last_ff;
   end

   bgc_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.data;
   assign rsp_tlast = head.last;

endmodule

FILE: tb/big5_gb_code_converter_core_tb.sv
// Self-checking testbench for the Big5 / GB2312 code converter core.
// Drives byte and table-load beats, predicts every output byte and compares.
// Depends on bgc_pkg and big5_gb_code_converter_core.
`timescale 1ns / 1ps

module big5_gb_code_converter_core_tb;
   import bgc_pkg::*;

   localparam int unsigned BIG5_DEPTH    = 16384;
   localparam int unsigned GB_DEPTH      = 8192;
   // Number of character codes that valid pairs can address in each table.
   localparam int B5_CODE_COUNT = (int'(B5_LEAD_HI) - int'(B5_LEAD_LO) + 1) * int'(B5_ROW_LEN);
   localparam int GB_CODE_COUNT =
      (int'(GB_LEAD2_HI) - int'(GB_LEAD2_LO) + 1 + int'(GB_LEAD2_ROW)) * int'(GB_ROW_LEN);
   localparam int RANDOM_ITEMS  = 800;
   localparam int PRELOAD_WORDS = 96;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      logic        mode;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        table_select;
      logic [13:0] table_index;
      logic [15:0] table_word;
   } stream_item_type;

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // data_byte[7:0], table_index[21:8], table_word[37:22]
   logic        req_tlast = 1'b0; // last_byte
   logic [1:0]  req_tuser = '0;  // mode[0], table_select[1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // out_byte[7:0]
   logic        rsp_tlast;       // out_last
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0; // direction

   // Shadow copy of the converter state.
   logic [15:0]  big5_table [BIG5_DEPTH];
   logic [15:0]  gb_table [GB_DEPTH];
   bit           big5_written [BIG5_DEPTH];
   bit           gb_written [GB_DEPTH];
   int           big5_loaded_codes [$];
   int           gb_loaded_codes [$];
   logic         lead_held = 1'b0;
   logic [7:0]   held_lead = '0;
   logic         direction_reg = DIR_BIG5_TO_GB;
   bgc_beat_type pending_out_bytes [$];

   int           error_count = 0;
   int           items_sent = 0;
   int           burst_left = 0;
   int           cycle_count = 0;
   int           stall_left = 0;
   stall_style_type stall_style = STALL_NONE;

   // Pairs at the corners of each code space, and pairs just outside it.
   logic [15:0] big5_edge_pairs [$] = '{16'ha140, 16'ha17e, 16'ha1a1, 16'ha1fe,
                                        16'hf940, 16'hf9fe};
   logic [15:0] big5_bad_pairs [$]  = '{16'ha040, 16'hfafe, 16'ha17f, 16'ha1ff};
   logic [15:0] gb_edge_pairs [$]   = '{16'ha1a1, 16'ha9fe, 16'hb0a1, 16'hf7fe};
   logic [15:0] gb_bad_pairs [$]    = '{16'haaa1, 16'hf8fe, 16'hb0a0, 16'ha1ff};

   big5_gb_code_converter_core #(
      .BIG5_TABLE_DEPTH(BIG5_DEPTH),
      .GB_TABLE_DEPTH  (GB_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Table index of a Big5 pair, or -1 when the pair lies outside the code space.
   function automatic int big5_index(input logic [7:0] lead, input logic [7:0] trail);
      int row;
      if (lead < B5_LEAD_LO || lead > B5_LEAD_HI) return -1;
      row = (int'(lead) - int'(B5_LEAD_LO)) * int'(B5_ROW_LEN);
      if (trail >= B5_TRAIL1_LO && trail <= B5_TRAIL1_HI)
         row = row + int'(trail) - int'(B5_TRAIL1_LO);
      else if (trail >= B5_TRAIL2_LO && trail <= B5_TRAIL2_HI)
         row = row + int'(trail) - int'(B5_TRAIL2_LO) + int'(B5_TRAIL2_OFS);
      else
         return -1;
      return (row < BIG5_DEPTH) ? row : -1;
   endfunction

   // Table index of a GB2312 pair, or -1 when the pair lies outside the code space.
   function automatic int gb_index(input logic [7:0] lead, input logic [7:0] trail);
      int row;
      if (trail < GB_TRAIL_LO || trail > GB_TRAIL_HI) return -1;
      if (lead >= GB_LEAD1_LO && lead <= GB_LEAD1_HI)
         row = int'(lead) - int'(GB_LEAD1_LO);
      else if (lead >= GB_LEAD2_LO && lead <= GB_LEAD2_HI)
         row = int'(lead) - int'(GB_LEAD2_LO) + int'(GB_LEAD2_ROW);
      else
         return -1;
      row = row * int'(GB_ROW_LEN) + int'(trail) - int'(GB_TRAIL_LO);
      return (row < GB_DEPTH) ? row : -1;
   endfunction

   // Lead and trail bytes that address a given entry, lead in the high half.
   function automatic logic [15:0] pair_for_index(input logic dir, input int idx);
      int row;
      int col;
      logic [15:0] pair;
      if (dir == DIR_GB_TO_BIG5) begin
         row = idx / int'(GB_ROW_LEN);
         col = idx % int'(GB_ROW_LEN);
         pair[15:8] = (row < int'(GB_LEAD2_ROW)) ? 8'(int'(GB_LEAD1_LO) + row)
                      : 8'(int'(GB_LEAD2_LO) + row - int'(GB_LEAD2_ROW));
         pair[7:0]  = 8'(int'(GB_TRAIL_LO) + col);
      end else begin
         row = idx / int'(B5_ROW_LEN);
         col = idx % int'(B5_ROW_LEN);
         pair[15:8] = 8'(int'(B5_LEAD_LO) + row);
         pair[7:0]  = (col < int'(B5_TRAIL2_OFS)) ? 8'(int'(B5_TRAIL1_LO) + col)
                      : 8'(int'(B5_TRAIL2_LO) + col - int'(B5_TRAIL2_OFS));
      end
      return pair;
   endfunction

   // True when converting the pair would not read an entry that was never loaded.
   function automatic bit pair_is_readable(input logic dir, input logic [7:0] lead,
                                           input logic [7:0] trail);
      int idx;
      if (dir == DIR_GB_TO_BIG5) begin
         idx = gb_index(lead, trail);
         return idx < 0 || gb_written[idx];
      end
      idx = big5_index(lead, trail);
      return idx < 0 || big5_written[idx];
   endfunction

   function automatic logic [15:0] translate_pair(input logic dir, input logic [7:0] lead,
                                                  input logic [7:0] trail);
      int idx;
      if (dir == DIR_GB_TO_BIG5) begin
         idx = gb_index(lead, trail);
         return (idx < 0) ? GB_TO_B5_REPL : gb_table[idx];
      end
      idx = big5_index(lead, trail);
      return (idx < 0) ? B5_TO_GB_REPL : big5_table[idx];
   endfunction

   function automatic void queue_pair(input logic [7:0] lead, input logic [7:0] trail,
                                      input logic last);
      logic [15:0] code;
      code = translate_pair(direction_reg, lead, trail);
      pending_out_bytes.push_back('{data: code[15:8], last: 1'b0});
      pending_out_bytes.push_back('{data: code[7:0], last: last});
   endfunction

   // Advances the shadow state by one accepted beat and queues its output bytes.
   function automatic void predict_conversion(input stream_item_type item);
      int idx;
      idx = int'(item.table_index);
      if (item.mode == MODE_LOAD) begin
         if (item.table_select == TABLE_BIG5_TO_GB) begin
            if (idx < BIG5_DEPTH) begin
               if (!big5_written[idx] && idx < B5_CODE_COUNT) big5_loaded_codes.push_back(idx);
               big5_table[idx]   = item.table_word;
               big5_written[idx] = 1'b1;
            end
         end else if (idx < GB_DEPTH) begin
            if (!gb_written[idx] && idx < GB_CODE_COUNT) gb_loaded_codes.push_back(idx);
            gb_table[idx]   = item.table_word;
            gb_written[idx] = 1'b1;
         end
      end else if (lead_held) begin
         lead_held = 1'b0;
         queue_pair(held_lead, item.data_byte, item.last_byte);
      end else if (item.data_byte[7]) begin
         // A lead byte at the end of the string is paired with a zero trail.
         if (item.last_byte) queue_pair(item.data_byte, 8'h00, 1'b1);
         else begin
            lead_held = 1'b1;
            held_lead = item.data_byte;
         end
      end else begin
         pending_out_bytes.push_back('{data: item.data_byte, last: item.last_byte});
      end
   endfunction

   function automatic stream_item_type convert_item(input logic [7:0] code_byte,
                                                    input logic last);
      stream_item_type item;
      item.mode         = MODE_CONVERT;
      item.data_byte    = code_byte;
      item.last_byte    = last;
      item.table_select = 1'($urandom_range(0, 1));
      item.table_index  = 14'($urandom());
      item.table_word   = 16'($urandom());
      return item;
   endfunction

   function automatic stream_item_type load_item(input logic sel, input int idx,
                                                 input logic [15:0] word);
      stream_item_type item;
      item.mode         = MODE_LOAD;
      item.data_byte    = 8'($urandom());
      item.last_byte    = 1'($urandom_range(0, 1));
      item.table_select = sel;
      item.table_index  = 14'(idx);
      item.table_word   = word;
      return item;
   endfunction

   function automatic logic random_last();
      return ($urandom_range(0, 7) == 0);
   endfunction

   // Random trail byte that keeps the pair away from unloaded entries.
   function automatic logic [7:0] safe_trail(input logic [7:0] lead);
      logic [7:0] trail;
      do trail = 8'($urandom_range(0, 255));
      while (!pair_is_readable(direction_reg, lead, trail));
      return trail;
   endfunction

   // Sends one beat, in bursts separated by random gaps, and predicts its outputs.
   task automatic send_item(input stream_item_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                      : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, item.table_word, item.table_index, item.data_byte};
      req_tlast  <= item.last_byte;
      req_tuser  <= {item.table_select, item.mode};
      do @(posedge clock); while (req_tready !== 1'b1);
      burst_left--;
      items_sent++;
      predict_conversion(item);
   endtask

   task automatic send_convert(input logic [7:0] code_byte, input logic last);
      send_item(convert_item(code_byte, last));
   endtask

   task automatic send_load(input logic sel, input int idx, input logic [15:0] word);
      send_item(load_item(sel, idx, word));
   endtask

   task automatic send_pair(input logic [15:0] pair, input logic last);
      send_convert(pair[15:8], 1'b0);
      send_convert(pair[7:0], last);
   endtask

   // Stops the input, lets every expected byte out and gives the pipeline time to settle.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_out_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic dir);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_data  <= dir;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      direction_reg = dir;
   endtask

   // Loads the corner entries, a spread of random entries and a few out-of-range words.
   task automatic test_table_loads();
      logic [15:0] word;
      foreach (big5_edge_pairs[i]) begin
         word = (i == 0) ? 16'h0000 : (i == 1) ? 16'hffff : 16'($urandom());
         send_load(TABLE_BIG5_TO_GB, big5_index(big5_edge_pairs[i][15:8],
                   big5_edge_pairs[i][7:0]), word);
      end
      foreach (gb_edge_pairs[i])
         send_load(TABLE_GB_TO_BIG5, gb_index(gb_edge_pairs[i][15:8], gb_edge_pairs[i][7:0]),
                   16'($urandom()));
      repeat (PRELOAD_WORDS) begin
         send_load(TABLE_BIG5_TO_GB, $urandom_range(0, B5_CODE_COUNT - 1), 16'($urandom()));
         send_load(TABLE_GB_TO_BIG5, $urandom_range(0, GB_CODE_COUNT - 1), 16'($urandom()));
      end
      // Indices past the GB table must be dropped, not folded onto low entries.
      send_load(TABLE_GB_TO_BIG5, GB_DEPTH, 16'($urandom()));
      send_load(TABLE_GB_TO_BIG5, BIG5_DEPTH - 1, 16'($urandom()));
      send_load(TABLE_BIG5_TO_GB, BIG5_DEPTH - 1, 16'hffff);
   endtask

   task automatic test_passthrough();
      send_convert(8'h00, 1'b0);
      send_convert(8'h7f, 1'b1);
      send_convert(8'h41, 1'b0);
   endtask

   task automatic test_big5_pairs();
      write_direction(DIR_BIG5_TO_GB);
      foreach (big5_edge_pairs[i]) send_pair(big5_edge_pairs[i], 1'(i % 2));
      foreach (big5_bad_pairs[i]) send_pair(big5_bad_pairs[i], 1'(i % 2));
   endtask

   task automatic test_gb_pairs();
      write_direction(DIR_GB_TO_BIG5);
      foreach (gb_edge_pairs[i]) send_pair(gb_edge_pairs[i], 1'(i % 2));
      foreach (gb_bad_pairs[i]) send_pair(gb_bad_pairs[i], 1'(i % 2));
   endtask

   // A table load between lead and trail leaves the lead held; the trail reads the new word.
   task automatic test_load_while_lead_held();
      send_convert(8'ha1, 1'b0);
      send_load(TABLE_BIG5_TO_GB, big5_index(8'ha1, 8'ha1), 16'($urandom()));
      send_convert(8'ha1, 1'b1);
   endtask

   // A string that ends on a lead byte gives the replacement pair of either direction.
   task automatic test_lead_at_end_of_string();
      write_direction(DIR_GB_TO_BIG5);
      send_convert(8'h80, 1'b1);
      write_direction(DIR_BIG5_TO_GB);
      send_convert(8'hff, 1'b1);
   endtask

   // The direction in force when the trail arrives decides the mapping.
   task automatic test_direction_change_while_held();
      send_convert(8'ha1, 1'b0);
      write_direction(DIR_GB_TO_BIG5);
      send_convert(8'ha1, 1'b1);
      send_convert(8'ha1, 1'b0);
      write_direction(DIR_BIG5_TO_GB);
      send_convert(8'ha1, 1'b0);
   endtask

   task automatic send_random_load();
      logic sel;
      int idx;
      sel = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, BIG5_DEPTH - 1);
      else if (sel == TABLE_GB_TO_BIG5) idx = $urandom_range(0, GB_CODE_COUNT - 1);
      else idx = $urandom_range(0, B5_CODE_COUNT - 1);
      send_load(sel, idx, 16'($urandom()));
   endtask

   // One short piece of text: mostly well-formed pairs and plain bytes, some noise.
   task automatic send_random_sequence();
      int pick;
      int idx;
      logic [7:0] lead;
      logic [15:0] pair;
      if (lead_held) begin
         send_convert(safe_trail(held_lead), random_last());
         return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         send_convert(8'($urandom_range(0, 127)), random_last());
      end else if (pick < 68) begin
         if (direction_reg == DIR_GB_TO_BIG5)
            idx = gb_loaded_codes[$urandom_range(0, gb_loaded_codes.size() - 1)];
         else
            idx = big5_loaded_codes[$urandom_range(0, big5_loaded_codes.size() - 1)];
         pair = pair_for_index(direction_reg, idx);
         send_convert(pair[15:8], 1'b0);
         if ($urandom_range(0, 19) == 0) send_random_load();
         send_convert(pair[7:0], random_last());
      end else if (pick < 78) begin
         lead = 8'h80 | 8'($urandom_range(0, 127));
         send_convert(lead, 1'b0);
         send_convert(safe_trail(lead), random_last());
      end else if (pick < 83) begin
         send_convert(8'h80 | 8'($urandom_range(0, 127)), 1'b1);
      end else if (pick < 95) begin
         send_random_load();
      end else begin
         // Raw noise; a high byte here that does not end the string becomes a lead for the next sequence.
         send_convert(8'($urandom_range(0, 255)), random_last());
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      int target;
      for (phase = 0; phase < 4; phase++) begin
         if (phase == 3) write_direction(1'($urandom_range(0, 1)));
         else write_direction((phase % 2 == 1) ? DIR_GB_TO_BIG5 : DIR_BIG5_TO_GB);
         target = items_sent + RANDOM_ITEMS / 4;
         while (items_sent < target) send_random_sequence();
      end
   endtask

   // Output checker and receiver stall pattern.
   always @(posedge clock) begin : out_checker
      bgc_beat_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_out_bytes.size() == 0) begin
            $error("out_byte: expected nothing, actual %h (out_last %b)", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_out_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               $error("out_byte: expected %h, actual %h", want.data, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("out_last: expected %b, actual %b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_style)
         STALL_NONE:  rsp_tready <= 1'b1;
         STALL_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:     rsp_tready <= (stall_left % 8 == 0);
      endcase
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int drain_wait;
      drain_wait = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_table_loads();
      test_passthrough();
      test_big5_pairs();
      test_load_while_lead_held();
      test_gb_pairs();
      test_lead_at_end_of_string();
      test_direction_change_while_held();
      test_random_traffic();

      // Drain the remaining bytes, then watch a little longer for strays.
      req_tvalid <= 1'b0;
      while (pending_out_bytes.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_out_bytes.size() != 0) begin
         $error("out_byte: %0d expected beats never arrived", pending_out_bytes.size());
         error_count++;
      end
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
